/* src/mec_pkg.sv */
// Shared types, constants and saturation helper for the escape-time colouring block.
package mec_pkg;

  // Pixel coordinates and the width register.
  localparam int PIXEL_BITS   = 12;
  localparam int COORD_BITS   = 12;
  localparam int WIDTH_BITS   = 13;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(512);
  localparam int COORD_SCALE  = 20;

  // Signed Q17.30 datapath.
  localparam int FRAC_BITS    = 30;
  localparam int Q_BITS       = 48;
  localparam int MAG_BITS     = Q_BITS - 1;
  localparam int SUM_BITS     = Q_BITS + 2;
  localparam int ESC_BITS     = Q_BITS + 1;
  localparam logic signed [Q_BITS-1:0] QMAX =
    Q_BITS'((64'd1 << MAG_BITS) - 64'd1);
  localparam logic signed [Q_BITS-1:0] HALF_Q30 = Q_BITS'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [Q_BITS-1:0] OFFSET_Y = Q_BITS'(64'd622770258);
  localparam logic [ESC_BITS-1:0] ESCAPE_LIMIT = ESC_BITS'(64'd1 << 46);

  // Multiplier split: magnitudes are cut into two halves.
  localparam int HALF_BITS    = 24;
  localparam int HI_BITS      = MAG_BITS - HALF_BITS;
  localparam int PROD_BITS    = 2 * HALF_BITS;
  localparam int ACC_BITS     = 2 * MAG_BITS;
  localparam int MUL_STEP_BITS = 3;
  localparam logic [MUL_STEP_BITS-1:0] MUL_PARTS = MUL_STEP_BITS'(4);
  localparam logic [MUL_STEP_BITS-1:0] MUL_LAST  = MUL_STEP_BITS'(5);

  // Iterative divider.
  localparam int DIV_N_BITS   = COORD_BITS + FRAC_BITS;
  localparam int DIVISOR_BITS = WIDTH_BITS + 5;
  localparam int DIV_CNT_BITS = $clog2(DIV_N_BITS + 1);

  // Iteration count and palette.
  localparam int MAX_ITER     = 1000;
  localparam int COUNT_BITS   = 10;
  localparam int ITER_BITS    = ($clog2(MAX_ITER + 1) > COUNT_BITS) ?
                                $clog2(MAX_ITER + 1) : COUNT_BITS;
  localparam int GREEN_BITS   = 16;
  localparam int BLUE_BITS    = 15;
  localparam logic [BLUE_BITS-1:0] BLUE_Q16 = BLUE_BITS'(19661);
  localparam longint GREEN_SCALE = 7 * 131072;
  localparam longint GREEN_BIAS  = 10 * MAX_ITER;
  localparam longint GREEN_DIV   = 20 * MAX_ITER;

  // The division by GREEN_DIV is a multiply by its reciprocal rounded up, followed by
  // a shift; the shift is wide enough that the result is exact for every count below
  // MAX_ITER.
  localparam int     GREEN_SHIFT     = 45;
  localparam int     GREEN_PROD_BITS = 64;
  localparam longint GREEN_RECIP     = ((64'sd1 <<< GREEN_SHIFT) + GREEN_DIV - 1) / GREEN_DIV;
  localparam longint GREEN_MUL       = GREEN_SCALE * GREEN_RECIP;
  localparam longint GREEN_ADD       = GREEN_BIAS * GREEN_RECIP;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_CHECK,
    S_MUV,
    S_SQU_GO,
    S_SQU,
    S_SQV,
    S_DONE
  } state_t;

  // Symmetric saturation of a widened sum back to Q17.30.
  function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [SUM_BITS-1:0] s);
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = {{(SUM_BITS-Q_BITS){1'b0}}, QMAX};
    lo = -hi;
    if (s > hi) begin
      return QMAX;
    end else if (s < lo) begin
      return -QMAX;
    end
    return s[Q_BITS-1:0];
  endfunction

endpackage

/* src/mec_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module mec_div import mec_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DIV_N_BITS-1:0]   dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output logic                    done,
  output logic [DIV_N_BITS-1:0]   quotient
);

  logic [DIVISOR_BITS-1:0] rem_r;
  logic [DIVISOR_BITS-1:0] dvsr_r;
  logic [DIV_N_BITS-1:0]   quo_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    done_r;

  logic [DIVISOR_BITS:0]   trial;
  logic [DIVISOR_BITS:0]   diff;
  logic                    fits;
  logic [DIVISOR_BITS-1:0] rem_step;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_N_BITS-1]};
    diff     = trial - {1'b0, dvsr_r};
    fits     = trial >= {1'b0, dvsr_r};
    rem_step = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DIV_CNT_BITS'(DIV_N_BITS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_BITS'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_step;
      quo_r <= {quo_r[DIV_N_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/mec_mulq.sv */
// Signed Q17.30 multiplier built from four half-width partial products on one multiplier.
module mec_mulq import mec_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [Q_BITS-1:0] op_a,
  input  logic signed [Q_BITS-1:0] op_b,
  output logic                     done,
  output logic signed [Q_BITS-1:0] product
);

  logic                     busy_r;
  logic                     done_r;
  logic [MUL_STEP_BITS-1:0] step_r;
  logic [MAG_BITS-1:0]      ma_r;
  logic [MAG_BITS-1:0]      mb_r;
  logic                     neg_r;
  logic [PROD_BITS-1:0]     prod_r;
  logic [1:0]               pos_r;
  logic [ACC_BITS-1:0]      acc_r;
  logic signed [Q_BITS-1:0] res_r;

  logic [Q_BITS-1:0]    abs_a;
  logic [Q_BITS-1:0]    abs_b;
  logic [HALF_BITS-1:0] part_a;
  logic [HALF_BITS-1:0] part_b;
  logic [ACC_BITS-1:0]  shifted;
  logic                 over;
  logic [MAG_BITS-1:0]  mag_res;

  always_comb begin
    abs_a  = op_a[Q_BITS-1] ? (~op_a + 1'b1) : op_a;
    abs_b  = op_b[Q_BITS-1] ? (~op_b + 1'b1) : op_b;
    part_a = step_r[1] ? HALF_BITS'(ma_r[MAG_BITS-1:HALF_BITS]) : ma_r[HALF_BITS-1:0];
    part_b = step_r[0] ? HALF_BITS'(mb_r[MAG_BITS-1:HALF_BITS]) : mb_r[HALF_BITS-1:0];
    unique case (pos_r)
      2'd0:    shifted = ACC_BITS'(prod_r);
      2'd1:    shifted = ACC_BITS'(prod_r) << HALF_BITS;
      2'd2:    shifted = ACC_BITS'(prod_r) << (2 * HALF_BITS);
      default: shifted = '0;
    endcase
    // The Q.30 result is the product shifted down; anything above it saturates.
    over    = |acc_r[ACC_BITS-1:FRAC_BITS+MAG_BITS];
    mag_res = over ? QMAX[MAG_BITS-1:0] : acc_r[FRAC_BITS+MAG_BITS-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == MUL_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= abs_a[MAG_BITS-1:0];
      mb_r  <= abs_b[MAG_BITS-1:0];
      neg_r <= op_a[Q_BITS-1] ^ op_b[Q_BITS-1];
      acc_r <= '0;
    end else if (busy_r) begin
      if (step_r < MUL_PARTS) begin
        prod_r <= part_a * part_b;
        pos_r  <= {step_r[1] & step_r[0], step_r[1] ^ step_r[0]};
      end
      if (step_r != '0 && step_r <= MUL_PARTS) begin
        acc_r <= acc_r + shifted;
      end
      if (step_r == MUL_LAST) begin
        res_r <= neg_r ? -$signed({1'b0, mag_res}) : $signed({1'b0, mag_res});
      end
    end
  end

  assign done    = done_r;
  assign product = res_r;

endmodule

/* src/mandelbrot_escape_colour_top.sv */
// Top level of the Mandelbrot escape-time colouring block: sequencer, state and ports.
//
// Each accepted request carries one pixel (pixel_x, pixel_y) and yields exactly one result
// request with the escape count, an in-set flag and the green and blue palette levels.
// The block works on one pixel at a time and holds in_ready low from acceptance until its
// result has been moved into the output register; the output register lets the next pixel
// be accepted while the previous result still waits for out_ready. Two shared units do the
// arithmetic: a restoring divider, used once for each coordinate, and one Q17.30 multiplier
// that forms each product from four 24x24 partial products on a single hardware multiplier.
// One iteration of z = z^2 + c takes three products. The green level comes from a constant
// reciprocal product in the cycle that ends the loop.
// The image_width register is written through the cfg port, which is always ready; write
// it only while no pixel is in flight. A width of zero behaves as a width of one.
module mandelbrot_escape_colour_top import mec_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [WIDTH_BITS-1:0] cfg_image_width,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIXEL_BITS-1:0] in_pixel_x,
  input  logic [PIXEL_BITS-1:0] in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COUNT_BITS-1:0] out_iteration_count,
  output logic                  out_in_set,
  output logic [GREEN_BITS-1:0] out_green_level,
  output logic [BLUE_BITS-1:0]  out_blue_level
);

  state_t state_r, state_nxt;

  logic [WIDTH_BITS-1:0]    image_width_r;
  logic [COORD_BITS-1:0]    py_r, py_nxt;
  logic signed [Q_BITS-1:0] xn_r, xn_nxt;
  logic signed [Q_BITS-1:0] yn_r, yn_nxt;
  logic signed [Q_BITS-1:0] u_r, u_nxt;
  logic signed [Q_BITS-1:0] v_r, v_nxt;
  logic signed [Q_BITS-1:0] u2_r, u2_nxt;
  logic signed [Q_BITS-1:0] v2_r, v2_nxt;
  logic [ITER_BITS-1:0]     k_r, k_nxt;
  logic [GREEN_BITS-1:0]    green_r, green_nxt;

  logic                  out_valid_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic                  out_in_set_r;
  logic [GREEN_BITS-1:0] out_green_r;
  logic [BLUE_BITS-1:0]  out_blue_r;
  logic                  out_load;

  // Shared unit hookup.
  logic                     div_start;
  logic [DIV_N_BITS-1:0]    div_dividend;
  logic [DIVISOR_BITS-1:0]  div_divisor;
  logic                     div_done;
  logic [DIV_N_BITS-1:0]    div_q;
  logic                     mul_start;
  logic signed [Q_BITS-1:0] mul_a;
  logic signed [Q_BITS-1:0] mul_b;
  logic                     mul_done;
  logic signed [Q_BITS-1:0] mul_p;

  logic [WIDTH_BITS-1:0]      width_eff;
  logic [DIVISOR_BITS-1:0]    coord_div;
  logic [GREEN_PROD_BITS-1:0] green_prod;
  logic [ESC_BITS-1:0]        mag_sum;
  logic                       escape_ok;
  logic                       below_max;
  logic signed [SUM_BITS-1:0] v_sum;
  logic signed [SUM_BITS-1:0] u_sum;

  mec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  mec_mulq u_mulq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // Datapath terms that do not depend on the state.
  always_comb begin
    width_eff = (image_width_r == '0) ? WIDTH_BITS'(1) : image_width_r;
    coord_div = DIVISOR_BITS'(width_eff) * DIVISOR_BITS'(COORD_SCALE);
    // Green level: (count * 7 * 2^17 + rounding bias) / (20 * MAX_ITER), with the
    // division done as a reciprocal product; the quotient sits above GREEN_SHIFT.
    green_prod = GREEN_PROD_BITS'(k_r) * GREEN_PROD_BITS'(GREEN_MUL)
                 + GREEN_PROD_BITS'(GREEN_ADD);
    mag_sum   = {1'b0, u2_r} + {1'b0, v2_r};
    escape_ok = mag_sum < ESCAPE_LIMIT;
    below_max = k_r < ITER_BITS'(MAX_ITER);
    // v' = 2*u*v + yn and u' = u^2 - v^2 + xn, both widened before saturation.
    v_sum = {mul_p[Q_BITS-1], mul_p, 1'b0} + {{2{yn_r[Q_BITS-1]}}, yn_r};
    u_sum = {{2{u2_r[Q_BITS-1]}}, u2_r} - {{2{v2_r[Q_BITS-1]}}, v2_r}
            + {{2{xn_r[Q_BITS-1]}}, xn_r};
  end

  // Sequencer: next state, shared unit requests and register updates.
  always_comb begin
    state_nxt    = state_r;
    py_nxt       = py_r;
    xn_nxt       = xn_r;
    yn_nxt       = yn_r;
    u_nxt        = u_r;
    v_nxt        = v_r;
    u2_nxt       = u2_r;
    v2_nxt       = v2_r;
    k_nxt        = k_r;
    green_nxt    = green_r;
    div_start    = 1'b0;
    div_dividend = DIV_N_BITS'(in_pixel_x[COORD_BITS-1:0]) << FRAC_BITS;
    div_divisor  = coord_div;
    mul_start    = 1'b0;
    mul_a        = u_r;
    mul_b        = v_r;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          div_start = 1'b1;
          py_nxt    = in_pixel_y[COORD_BITS-1:0];
          u_nxt     = '0;
          v_nxt     = '0;
          u2_nxt    = '0;
          v2_nxt    = '0;
          k_nxt     = ITER_BITS'(1);
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        div_dividend = DIV_N_BITS'(py_r) << FRAC_BITS;
        if (div_done) begin
          xn_nxt    = Q_BITS'(div_q) - HALF_Q30;
          div_start = 1'b1;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          yn_nxt    = Q_BITS'(div_q) + OFFSET_Y;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (below_max && escape_ok) begin
          mul_start = 1'b1;
          state_nxt = S_MUV;
        end else if (!below_max) begin
          state_nxt = S_DONE;
        end else begin
          green_nxt = GREEN_BITS'(green_prod >> GREEN_SHIFT);
          state_nxt = S_DONE;
        end
      end
      S_MUV: begin
        if (mul_done) begin
          v_nxt     = sat_q(v_sum);
          u_nxt     = sat_q(u_sum);
          state_nxt = S_SQU_GO;
        end
      end
      S_SQU_GO: begin
        mul_start = 1'b1;
        mul_a     = u_r;
        mul_b     = u_r;
        state_nxt = S_SQU;
      end
      S_SQU: begin
        mul_a = v_r;
        mul_b = v_r;
        if (mul_done) begin
          u2_nxt    = mul_p;
          mul_start = 1'b1;
          state_nxt = S_SQV;
        end
      end
      S_SQV: begin
        if (mul_done) begin
          v2_nxt    = mul_p;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      image_width_r <= WIDTH_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        image_width_r <= cfg_image_width;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    py_r    <= py_nxt;
    xn_r    <= xn_nxt;
    yn_r    <= yn_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    u2_r    <= u2_nxt;
    v2_r    <= v2_nxt;
    k_r     <= k_nxt;
    green_r <= green_nxt;
    if (out_load) begin
      out_count_r  <= k_r[COUNT_BITS-1:0];
      out_in_set_r <= !below_max;
      out_green_r  <= below_max ? green_r : '0;
      out_blue_r   <= below_max ? BLUE_Q16 : '0;
    end
  end

  assign cfg_ready           = 1'b1;
  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_in_set          = out_in_set_r;
  assign out_green_level     = out_green_r;
  assign out_blue_level      = out_blue_r;

endmodule

/* tb/tb_mandelbrot_escape_colour_top.sv */
// Self-checking testbench for the Mandelbrot escape-time coloring block.
`timescale 1ns / 100ps

module tb_mandelbrot_escape_colour_top import mec_pkg::*;;

  // Run control. The slowest pixels are the ones that stay in the set; the
  // limit covers every pixel of this stimulus running as long as those, with
  // the longest gaps, several times over.
  localparam int CYCLE_LIMIT  = 60_000_000;
  localparam int HOLD_CYCLES  = 2000;
  localparam int IDLE_SETTLE  = 8;
  localparam int FINAL_SETTLE = 200;

  // Fixed-point constants of the signed Q17.30 datapath.
  localparam int     Q_FRAC      = 30;
  localparam longint Q_SAT       = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint HALF_ONE    = 64'sd1 << 29;
  localparam longint IMAG_OFFSET = 64'sd622770258;
  localparam longint ESCAPE_Q30  = 64'sd1 << 46;
  localparam logic [63:0] FRAC_MASK = (64'd1 << Q_FRAC) - 64'd1;
  localparam logic [63:0] WIDTH_SCALE = 64'd20;
  localparam logic [BLUE_BITS-1:0] BLUE_LEVEL_Q16 = 15'd19661;

  typedef struct {
    logic [PIXEL_BITS-1:0] x;
    logic [PIXEL_BITS-1:0] y;
  } pixel_t;

  typedef struct {
    logic [COUNT_BITS-1:0] iteration_count;
    logic                  in_set;
    logic [GREEN_BITS-1:0] green_level;
    logic [BLUE_BITS-1:0]  blue_level;
  } escape_colour_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [WIDTH_BITS-1:0] cfg_image_width = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIXEL_BITS-1:0] in_pixel_x = '0;
  logic [PIXEL_BITS-1:0] in_pixel_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COUNT_BITS-1:0] out_iteration_count;
  logic                  out_in_set;
  logic [GREEN_BITS-1:0] out_green_level;
  logic [BLUE_BITS-1:0]  out_blue_level;

  // Pixels waiting to be offered, and the colors predicted for pixels that
  // the block has accepted but not yet returned.
  pixel_t         pixel_queue[$];
  escape_colour_t colour_queue[$];

  // The predictor's own copy of the width register.
  logic [WIDTH_BITS-1:0] width_model = 13'd512;

  // Random idling is switched per phase so that some phases run flat out.
  bit idle_on = 1'b0;
  bit hold_request = 1'b0;
  logic receiver_hold = 1'b0;

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int n_widths = 0;
  int n_in_set = 0;
  int deepest_escape = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  pixel_t next_pixel;
  escape_colour_t wanted;

  mandelbrot_escape_colour_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_image_width     (cfg_image_width),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_iteration_count (out_iteration_count),
    .out_in_set          (out_in_set),
    .out_green_level     (out_green_level),
    .out_blue_level      (out_blue_level)
  );

  always #5 clk = ~clk;

  // Symmetric saturation to +-(2^47 - 1).
  function automatic longint clamp_q30(longint a);
    if (a > Q_SAT) begin
      return Q_SAT;
    end
    if (a < -Q_SAT) begin
      return -Q_SAT;
    end
    return a;
  endfunction

  // Q.30 product from four partial products of the magnitudes, truncated
  // toward zero and saturated. An integer product at or past 2^17 saturates
  // before any fraction terms are added.
  function automatic longint q30_product(longint a, longint b);
    logic        neg;
    longint      sa;
    longint      sb;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] ah;
    logic [63:0] al;
    logic [63:0] bh;
    logic [63:0] bl;
    logic [63:0] hh;
    logic [63:0] m;
    longint      mv;
    neg = (a < 0) != (b < 0);
    sa = clamp_q30(a);
    sb = clamp_q30(b);
    ma = (sa < 0) ? 64'(-sa) : 64'(sa);
    mb = (sb < 0) ? 64'(-sb) : 64'(sb);
    ah = ma >> Q_FRAC;
    al = ma & FRAC_MASK;
    bh = mb >> Q_FRAC;
    bl = mb & FRAC_MASK;
    hh = ah * bh;
    if (hh >= (64'd1 << 17)) begin
      m = 64'(Q_SAT);
    end else begin
      m = (hh << Q_FRAC) + ah * bl + al * bh + ((al * bl) >> Q_FRAC);
      if (m > 64'(Q_SAT)) begin
        m = 64'(Q_SAT);
      end
    end
    mv = $signed(m);
    return neg ? -mv : mv;
  endfunction

  // Maps a pixel to c, runs z = z^2 + c until escape or the iteration cap,
  // and picks the palette levels for the final count.
  function automatic escape_colour_t escape_colour(logic [PIXEL_BITS-1:0] px,
                                                   logic [PIXEL_BITS-1:0] py,
                                                   logic [WIDTH_BITS-1:0] width);
    logic [63:0]    divisor;
    logic [63:0]    green;
    longint         cr;
    longint         ci;
    longint         zr;
    longint         zi;
    longint         zr_sq;
    longint         zi_sq;
    int             k;
    escape_colour_t res;
    // A width of zero divides as a width of one.
    divisor = WIDTH_SCALE * ((width == '0) ? 64'd1 : 64'(width));
    cr = $signed((64'(px) << Q_FRAC) / divisor) - HALF_ONE;
    ci = $signed((64'(py) << Q_FRAC) / divisor) + IMAG_OFFSET;
    zr = 0;
    zi = 0;
    zr_sq = 0;
    zi_sq = 0;
    for (k = 1; k < MAX_ITER && (zr_sq + zi_sq) < ESCAPE_Q30; k++) begin
      zi = clamp_q30(2 * q30_product(zr, zi) + ci);
      zr = clamp_q30(zr_sq - zi_sq + cr);
      zr_sq = q30_product(zr, zr);
      zi_sq = q30_product(zi, zi);
    end
    res.iteration_count = COUNT_BITS'(k);
    res.in_set = (k >= MAX_ITER);
    if (res.in_set) begin
      res.green_level = '0;
      res.blue_level = '0;
    end else begin
      green = (64'(k) * 64'd917504 + 64'd10 * 64'(MAX_ITER)) / (64'd20 * 64'(MAX_ITER));
      res.green_level = green[GREEN_BITS-1:0];
      res.blue_level = BLUE_LEVEL_Q16;
    end
    return res;
  endfunction

  // Idle stretches are mostly short, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 3);
    end
    if (r < 92) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(30, 120);
  endfunction

  task automatic queue_pixel(int x, int y);
    pixel_t p;
    p.x = PIXEL_BITS'(x);
    p.y = PIXEL_BITS'(y);
    pixel_queue.push_back(p);
    n_queued++;
  endtask

  task automatic queue_random_pixels(int count);
    for (int i = 0; i < count; i++) begin
      queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    end
  endtask

  // Returns once every queued pixel has been accepted and answered, then waits
  // out the settle period so the block is surely idle.
  task automatic wait_drained(int settle);
    while (!(n_accepted == n_queued && n_checked == n_accepted)) begin
      @(posedge clk);
    end
    repeat (settle) @(posedge clk);
  endtask

  // Writes the width register through its request channel, only while idle.
  task automatic set_width(int value);
    wait_drained(IDLE_SETTLE);
    cfg_valid <= 1'b1;
    cfg_image_width <= WIDTH_BITS'(value);
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    width_model = WIDTH_BITS'(value);
    n_widths++;
  endtask

  // Sender. A pixel request stays up, unchanged, until the block takes it.
  // The color for each accepted pixel is predicted at the edge it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        colour_queue.push_back(escape_colour(in_pixel_x, in_pixel_y, width_model));
        n_accepted++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
          send_gap = idle_length();
        end
      end
      // The request slot is free when nothing is offered or the offer was
      // just taken; otherwise the current offer is held as it is.
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          next_pixel = pixel_queue.pop_front();
          in_valid <= 1'b1;
          in_pixel_x <= next_pixel.x;
          in_pixel_y <= next_pixel.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Each result request is checked field by field against the
  // oldest prediction; out_ready stalls at random and during the long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (colour_queue.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("result with no pixel pending: count %0d in_set %0b green %0d blue %0d",
                     out_iteration_count, out_in_set, out_green_level, out_blue_level);
          end
        end else begin
          wanted = colour_queue.pop_front();
          if (out_iteration_count !== wanted.iteration_count ||
              out_in_set !== wanted.in_set ||
              out_green_level !== wanted.green_level ||
              out_blue_level !== wanted.blue_level) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch on result %0d: expected count %0d in_set %0b green %0d blue %0d",
                       n_checked, wanted.iteration_count, wanted.in_set,
                       wanted.green_level, wanted.blue_level);
              $display("  got count %0d in_set %0b green %0d blue %0d",
                       out_iteration_count, out_in_set, out_green_level, out_blue_level);
            end
          end
          if (wanted.in_set) begin
            n_in_set++;
          end else if (int'(wanted.iteration_count) > deepest_escape) begin
            deepest_escape = int'(wanted.iteration_count);
          end
        end
      end
      if (receiver_hold) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) begin
          stall_left = idle_length();
        end
      end
    end
  end

  // Long receiver hold-off, counted here. The sender keeps offering pixels,
  // so the output register and the pixel in flight fill and in_ready drops.
  initial begin
    wait (hold_request);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset width of 512: the view lands near the set boundary. The origin
    // pixel maps to c = -0.5 + 0.58i; the last two sit inside the main
    // cardioid and the period-3 bulb, so they run to the iteration cap.
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(3891, 1638);
    queue_pixel(3072, 205);

    // Width of one: c spans hundreds, so most pixels escape at once. The
    // pixel near (180, 179) starts inside the escape radius and its next
    // square overflows, exercising saturation of products and sums.
    set_width(1);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(3610, 3588);
    queue_pixel(3590, 3600);
    queue_pixel(2048, 2048);
    queue_pixel(12'hAAA, 12'h555);
    queue_pixel(12'h555, 12'hAAA);
    queue_pixel(12'hFFF, 12'h800);
    queue_pixel(12'h7FF, 12'hFFF);
    queue_pixel(1000, 500);
    queue_pixel(0, 2048);

    // A zero width must behave as a width of one.
    set_width(0);
    queue_pixel(4095, 4095);
    queue_pixel(2000, 3000);
    idle_on = 1'b1;
    queue_random_pixels(100);

    // Widths at and above the nominal maximum give the finest steps.
    set_width(8191);
    queue_pixel(4095, 4095);
    queue_pixel(2048, 1024);
    set_width(4096);
    queue_pixel(4095, 4095);
    queue_pixel(1234, 3210);

    // Random phase with the long receiver hold-off at its start.
    set_width(1);
    hold_request = 1'b1;
    queue_random_pixels(200);

    // A phase with no idling on either side.
    set_width(3);
    idle_on = 1'b0;
    queue_random_pixels(100);

    // Small random widths keep most pixels shallow.
    idle_on = 1'b1;
    for (int i = 0; i < 4; i++) begin
      set_width($urandom_range(1, 16));
      queue_random_pixels(50);
    end

    // A few pixels at a large random width, which may run deep.
    set_width($urandom_range(256, 8191));
    queue_random_pixels(6);

    wait_drained(FINAL_SETTLE);
    if (colour_queue.size() != 0) begin
      n_mismatch++;
      $display("%0d predicted colors never arrived", colour_queue.size());
    end
    $display("Checked %0d pixels over %0d width writes; %0d in the set, deepest escape %0d.",
             n_checked, n_widths, n_in_set, deepest_escape);
    $display("Run took %0d cycles with %0d failures.", cycle_count, n_mismatch);
    if (n_mismatch == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/mec_pkg.sv
src/mec_div.sv
src/mec_mulq.sv
src/mandelbrot_escape_colour_top.sv
tb/tb_mandelbrot_escape_colour_top.sv
